// ----- hw/rtl/sob_pkg.sv -----
`timescale 1ns / 1ps

package sob_pkg;

    // Default geometry limits for the line stores and the row counter.
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // Field and register widths.
    localparam int DIM_W   = 12;
    localparam int THR_W   = 8;
    localparam int PIX_W   = 8;
    localparam int POS_W   = 11;
    localparam int GRAD_W  = 11;
    localparam int ABS_W   = GRAD_W - 1;
    localparam int SQ_W    = 2 * ABS_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int MAG_W   = 8;
    localparam int ROOT_SQ_W = 2 * MAG_W;
    localparam int STEP_W  = 3;
    localparam int MIN_DIM = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    // Register values after reset.
    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST    = 12'd640;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST   = 12'd480;
    localparam logic [THR_W-1:0] EDGE_THRESHOLD_RST = 8'd64;

    // Gradient queue between the window front end and the magnitude unit.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [GRAD_W-1:0] t_grad;

    // One queued interior window: both gradients and where the centre sits.
    typedef struct packed {
        t_grad              grad_x;
        t_grad              grad_y;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic               last;
    } t_qent;

    // Queue status seen by the producer and the consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_EMIT
    } t_back_state;

endpackage

// ----- hw/rtl/sob_ram.sv -----
`timescale 1ns / 1ps

module sob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/sob_fifo.sv -----
`timescale 1ns / 1ps

module sob_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sob_pkg::t_qent i_push_data,
    input  logic           i_pop,
    output sob_pkg::t_qent o_data,
    output sob_pkg::t_qstat o_stat
);

    localparam int DEPTH = sob_pkg::QUEUE_DEPTH;
    localparam int PW    = sob_pkg::QPTR_W;
    localparam int CW    = sob_pkg::QCNT_W;

    sob_pkg::t_qent r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    // Entry storage; the head is read straight from the array.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (32'(r_count) == DEPTH);
    assign o_stat.empty = (r_count == '0);

`ifndef SYNTHESIS
    // The magnitude unit never takes a window that is not there.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("gradient queue popped while empty");
`endif

endmodule

// ----- hw/rtl/sob_front.sv -----
`timescale 1ns / 1ps

module sob_front #(
    parameter int MAX_WIDTH  = sob_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sob_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sob_pkg::DIM_W-1:0]   i_image_width,
    input  logic [sob_pkg::DIM_W-1:0]   i_image_height,
    input  logic                        i_pix_valid,
    output logic                        o_pix_ready,
    input  logic [sob_pkg::PIX_W-1:0]   i_pix_data,
    input  sob_pkg::t_qstat             i_qstat,
    output logic                        o_push,
    output sob_pkg::t_qent              o_push_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int PXW   = sob_pkg::PIX_W;
    localparam int PSW   = sob_pkg::POS_W;
    localparam int SUMW  = PXW + 2;
    localparam int MIND  = sob_pkg::MIN_DIM;

    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic           r_busy;
    logic [PXW-1:0] r_pix;
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [PXW-1:0] r_win [6];
    logic [PXW-1:0] top;
    logic [PXW-1:0] mid;
    logic [PXW-1:0] bot;
    logic [SUMW-1:0] sum_bot;
    logic [SUMW-1:0] sum_top;
    logic [SUMW-1:0] sum_right;
    logic [SUMW-1:0] sum_left;
    logic           col_wrap;
    logic           row_wrap;
    logic           interior;
    logic           accept;

    // Effective geometry: registers clamped into the supported range.
    always_comb begin
        if (32'(i_image_width) < MIND) begin
            w_eff = WW'(MIND);
        end else if (32'(i_image_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(i_image_width);
        end
        if (32'(i_image_height) < MIND) begin
            h_eff = HW'(MIND);
        end else if (32'(i_image_height) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(i_image_height);
        end
    end

    // A pixel is taken only out of reset, when the previous one is retired
    // and the queue can hold the window it may produce.
    assign o_pix_ready = i_rst_n && !r_busy && !i_qstat.full;
    assign accept      = i_pix_valid && o_pix_ready;

    // Line stores: older holds row r-2, newer holds row r-1. The read of
    // the current column is issued on the accepting beat.
    sob_ram #(
        .WIDTH (PXW),
        .DEPTH (MAX_WIDTH)
    ) u_older (
        .i_clk   (i_clk),
        .i_we    (r_busy),
        .i_waddr (r_col),
        .i_wdata (mid),
        .i_raddr (r_col),
        .o_rdata (top)
    );

    sob_ram #(
        .WIDTH (PXW),
        .DEPTH (MAX_WIDTH)
    ) u_newer (
        .i_clk   (i_clk),
        .i_we    (r_busy),
        .i_waddr (r_col),
        .i_wdata (bot),
        .i_raddr (r_col),
        .o_rdata (mid)
    );

    assign bot = r_pix;

    // Sobel sums. Window columns: r_win[0..2] is column c-2 (top to bottom),
    // r_win[3..5] is column c-1, and top/mid/bot is column c.
    assign sum_bot   = {2'b00, r_win[2]} + {1'b0, r_win[5], 1'b0} + {2'b00, bot};
    assign sum_top   = {2'b00, r_win[0]} + {1'b0, r_win[3], 1'b0} + {2'b00, top};
    assign sum_right = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, bot};
    assign sum_left  = {2'b00, r_win[0]} + {1'b0, r_win[1], 1'b0} + {2'b00, r_win[2]};

    // Position classification for the window that this pixel completes.
    assign col_wrap = (32'(r_col) + 32'd1) >= 32'(w_eff);
    assign row_wrap = (32'(r_row) + 32'd1) >= 32'(h_eff);
    assign interior = (32'(r_row) >= 32'd2) && (32'(r_col) >= 32'd2)
                      && (32'(r_row) < 32'(h_eff)) && (32'(r_col) < 32'(w_eff));

    assign o_push                = r_busy && interior;
    assign o_push_data.grad_x    = $signed({1'b0, sum_bot}) - $signed({1'b0, sum_top});
    assign o_push_data.grad_y    = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
    assign o_push_data.row       = PSW'(32'(r_row) - 32'd1);
    assign o_push_data.col       = PSW'(32'(r_col) - 32'd1);
    assign o_push_data.last      = ((32'(r_row) + 32'd1) == 32'(h_eff))
                                   && ((32'(r_col) + 32'd1) == 32'(w_eff));

    // Capture of the incoming pixel.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= i_pix_data;
        end
    end

    // Busy flag, raster counters and the sliding window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_col  <= '0;
            r_row  <= '0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy   <= 1'b0;
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top;
                r_win[4] <= mid;
                r_win[5] <= bot;
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= row_wrap ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // Each accepted pixel is retired on the next cycle before another enters.
    a_accept_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_busy && !o_pix_ready))
        else $error("pixel accepted while previous one still in flight");

    // The space check at acceptance keeps the queue from overflowing.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_qstat.full)
        else $error("window pushed into a full gradient queue");
`endif

endmodule

// ----- hw/rtl/sob_back.sv -----
`timescale 1ns / 1ps

module sob_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sob_pkg::THR_W-1:0]   i_edge_threshold,
    input  sob_pkg::t_qstat             i_qstat,
    input  sob_pkg::t_qent              i_qdata,
    output logic                        o_pop,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [sob_pkg::MAG_W-1:0]   o_magnitude,
    output logic                        o_is_edge,
    output logic [sob_pkg::POS_W-1:0]   o_centre_row,
    output logic [sob_pkg::POS_W-1:0]   o_centre_col,
    output logic                        o_frame_last
);

    localparam int AW   = sob_pkg::ABS_W;
    localparam int SQW  = sob_pkg::SQ_W;
    localparam int SMW  = sob_pkg::SUM_W;
    localparam int MW   = sob_pkg::MAG_W;
    localparam int RSW  = sob_pkg::ROOT_SQ_W;
    localparam int STW  = sob_pkg::STEP_W;
    localparam int PSW  = sob_pkg::POS_W;
    localparam int THW  = sob_pkg::THR_W;

    sob_pkg::t_back_state r_state;
    sob_pkg::t_back_state n_state;

    logic [AW-1:0]      r_ax;
    logic [AW-1:0]      r_ay;
    logic [PSW-1:0]     r_row;
    logic [PSW-1:0]     r_col;
    logic               r_last;
    logic [SQW-1:0]     r_sqx;
    logic [SQW-1:0]     r_sqy;
    logic [2*THW-1:0]   r_thr_sq;
    logic [SMW-1:0]     r_sum;
    logic [MW-1:0]      r_root;
    logic [STW-1:0]     r_step;
    logic               r_edge;
    logic               r_out_valid;
    logic [MW-1:0]      r_out_mag;
    logic               r_out_edge;
    logic [PSW-1:0]     r_out_row;
    logic [PSW-1:0]     r_out_col;
    logic               r_out_last;
    logic               load_out;
    logic [MW-1:0]      trial;
    logic [RSW-1:0]     trial_sq;
    sob_pkg::t_grad     neg_x;
    sob_pkg::t_grad     neg_y;

    assign neg_x    = -i_qdata.grad_x;
    assign neg_y    = -i_qdata.grad_y;
    assign trial    = r_root | (MW'(1) << r_step);
    assign trial_sq = RSW'(trial) * RSW'(trial);

    // Sequencer: take a window, square, add, eight root steps, hand off.
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            sob_pkg::ST_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_state = sob_pkg::ST_SQUARE;
                end
            end
            sob_pkg::ST_SQUARE: begin
                n_state = sob_pkg::ST_SUM;
            end
            sob_pkg::ST_SUM: begin
                n_state = sob_pkg::ST_ROOT;
            end
            sob_pkg::ST_ROOT: begin
                if (r_step == '0) begin
                    n_state = sob_pkg::ST_EMIT;
                end
            end
            sob_pkg::ST_EMIT: begin
                if (!r_out_valid || i_res_ready) begin
                    load_out = 1'b1;
                    n_state  = sob_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sob_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sob_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: absolute gradients, squares, sum, bit-by-bit square root.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ax   <= i_qdata.grad_x[sob_pkg::GRAD_W-1] ? AW'(neg_x) : AW'(i_qdata.grad_x);
            r_ay   <= i_qdata.grad_y[sob_pkg::GRAD_W-1] ? AW'(neg_y) : AW'(i_qdata.grad_y);
            r_row  <= i_qdata.row;
            r_col  <= i_qdata.col;
            r_last <= i_qdata.last;
        end
        if (r_state == sob_pkg::ST_SQUARE) begin
            r_sqx    <= SQW'(r_ax) * SQW'(r_ax);
            r_sqy    <= SQW'(r_ay) * SQW'(r_ay);
            r_thr_sq <= (2*THW)'(i_edge_threshold) * (2*THW)'(i_edge_threshold);
        end
        if (r_state == sob_pkg::ST_SUM) begin
            r_sum  <= SMW'(r_sqx) + SMW'(r_sqy);
            r_root <= '0;
            r_step <= STW'(MW - 1);
        end
        if (r_state == sob_pkg::ST_ROOT) begin
            if (SMW'(trial_sq) <= r_sum) begin
                r_root <= trial;
            end
            r_step <= r_step - 1'b1;
            r_edge <= r_sum > SMW'(r_thr_sq);
        end
    end

    // Output register: holds one result while the next window is worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            // Sums of 65536 and more have a root beyond the 8-bit range.
            r_out_mag  <= (r_sum[SMW-1:RSW] != '0) ? '1 : r_root;
            r_out_edge <= r_edge;
            r_out_row  <= r_row;
            r_out_col  <= r_col;
            r_out_last <= r_last;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_magnitude  = r_out_mag;
    assign o_is_edge    = r_out_edge;
    assign o_centre_row = r_out_row;
    assign o_centre_col = r_out_col;
    assign o_frame_last = r_out_last;

`ifndef SYNTHESIS
    // A result appears only after the root steps have finished.
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == sob_pkg::ST_EMIT))
        else $error("result loaded outside of the hand-off step");
`endif

endmodule

// ----- hw/rtl/sobel_edge_threshold.sv -----
`timescale 1ns / 1ps

// Sobel edge detector with threshold. Grey pixels enter in raster order on
// the s_axis side; for every interior window centre one beat leaves on the
// m_axis side with the saturated gradient magnitude, the edge flag and the
// centre position, tlast marking the last result of a frame. Border pixels
// produce no beat. The front end takes no new pixel until the last one is
// retired, set by the registered read of the two line stores followed by
// their write-back. Each interior window then passes through the magnitude
// unit (queue pop, squaring, sum, eight square-root steps, hand-off), which
// takes no new window until the last is handed off and so sets the sustained
// rate; a 4-entry queue between the two lets short bursts pass at the
// front-end pace. The line stores need no clearing after reset. Geometry and
// threshold are to be written by the user only while the block is idle; the
// block itself does not enforce this.

module sobel_edge_threshold #(
    parameter int MAX_WIDTH  = sob_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sob_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [sob_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sob_pkg::DIM_W-1:0]       i_cfg_wdata,
    // Pixel stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] grey_pixel
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // [7:0] magnitude,
                                                           // [18:8] centre_row,
                                                           // [29:19] centre_col,
                                                           // [31:30] zero
    output logic                            m_axis_tuser,  // [0] is_edge
    output logic                            m_axis_tlast   // frame_last
);

    localparam int DW  = sob_pkg::DIM_W;
    localparam int TW  = sob_pkg::THR_W;
    localparam int MW  = sob_pkg::MAG_W;
    localparam int PSW = sob_pkg::POS_W;

    logic [DW-1:0]      r_image_width;
    logic [DW-1:0]      r_image_height;
    logic [TW-1:0]      r_edge_threshold;
    logic               push;
    logic               pop;
    sob_pkg::t_qent     push_data;
    sob_pkg::t_qent     head;
    sob_pkg::t_qstat    qstat;
    logic [MW-1:0]      magnitude;
    logic [PSW-1:0]     centre_row;
    logic [PSW-1:0]     centre_col;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= sob_pkg::IMAGE_WIDTH_RST;
            r_image_height   <= sob_pkg::IMAGE_HEIGHT_RST;
            r_edge_threshold <= sob_pkg::EDGE_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sob_pkg::CFG_IMAGE_WIDTH:    r_image_width    <= i_cfg_wdata;
                sob_pkg::CFG_IMAGE_HEIGHT:   r_image_height   <= i_cfg_wdata;
                sob_pkg::CFG_EDGE_THRESHOLD: r_edge_threshold <= i_cfg_wdata[TW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Window front end with the line stores.
    sob_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_pix_valid    (s_axis_tvalid),
        .o_pix_ready    (s_axis_tready),
        .i_pix_data     (s_axis_tdata),
        .i_qstat        (qstat),
        .o_push         (push),
        .o_push_data    (push_data)
    );

    // Gradient queue.
    sob_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_data      (head),
        .o_stat      (qstat)
    );

    // Magnitude, threshold and output register.
    sob_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_edge_threshold (r_edge_threshold),
        .i_qstat          (qstat),
        .i_qdata          (head),
        .o_pop            (pop),
        .o_res_valid      (m_axis_tvalid),
        .i_res_ready      (m_axis_tready),
        .o_magnitude      (magnitude),
        .o_is_edge        (m_axis_tuser),
        .o_centre_row     (centre_row),
        .o_centre_col     (centre_col),
        .o_frame_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, centre_col, centre_row, magnitude};

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int LINE_MAX      = sob_pkg::MAX_WIDTH_DEF;
    localparam int ROWS_MAX      = sob_pkg::MAX_HEIGHT_DEF;
    localparam int DIM_BITS      = sob_pkg::DIM_W;
    localparam int THR_BITS      = sob_pkg::THR_W;
    localparam int MAG_BITS      = sob_pkg::MAG_W;
    localparam int POS_BITS      = sob_pkg::POS_W;
    localparam int IDX_BITS      = sob_pkg::CFG_IDX_W;
    localparam int RANDOM_PIXELS = 480;
    localparam int WIDE_PIXELS   = 60;
    localparam int TALL_PIXELS   = 30;
    localparam int DRAIN_CYCLES  = 32;
    localparam int LONG_HOLD     = 400;

    // Index 3 has no register behind it; writes there must be ignored.
    localparam logic [IDX_BITS-1:0] CFG_SPARE_INDEX = 2'd3;

    typedef enum int {
        PIX_NOISE,
        PIX_SOFT,
        PIX_STEP
    } t_pix_mode;

    typedef enum int {
        RX_FLOW,
        RX_CHOPPY,
        RX_SPARSE
    } t_rx_mode;

    typedef struct packed {
        logic [MAG_BITS-1:0] magnitude;
        logic                is_edge;
        logic [POS_BITS-1:0] centre_row;
        logic [POS_BITS-1:0] centre_col;
        logic                frame_last;
    } t_edge_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [IDX_BITS-1:0]  i_cfg_index = '0;
    logic [DIM_BITS-1:0]  i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;   // [7:0] grey_pixel
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;        // [7:0] magnitude, [18:8] centre_row,
                                               // [29:19] centre_col, [31:30] zero
    logic                 m_axis_tuser;        // [0] is_edge
    logic                 m_axis_tlast;

    // Mirror of the block: registers, line stores, window and raster position.
    logic [DIM_BITS-1:0] cfg_width     = sob_pkg::IMAGE_WIDTH_RST;
    logic [DIM_BITS-1:0] cfg_height    = sob_pkg::IMAGE_HEIGHT_RST;
    logic [THR_BITS-1:0] cfg_threshold = sob_pkg::EDGE_THRESHOLD_RST;
    bit   [7:0]       line_older [LINE_MAX];
    bit   [7:0]       line_newer [LINE_MAX];
    int               win_col [6];
    int unsigned      pos_row = 0;
    int unsigned      pos_col = 0;

    t_edge_result     edge_results_due [$];

    int error_count     = 0;
    int results_checked = 0;
    int edges_seen      = 0;
    int frame_ends_seen = 0;
    int pixels_sent     = 0;
    int reg_writes      = 0;
    int burst_left      = 0;
    int pix_base        = 0;
    int hold_req        = 0;
    int hold_ack        = 0;
    int hold_left       = 0;
    t_rx_mode rx_mode   = RX_FLOW;
    int rx_mode_left    = 0;

    sobel_edge_threshold i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Out-of-range geometry is clamped to [3, hi].
    function automatic int unsigned eff_dim(input logic [DIM_BITS-1:0] v,
                                            input int unsigned hi);
        if (32'(v) < unsigned'(sob_pkg::MIN_DIM)) return unsigned'(sob_pkg::MIN_DIM);
        if (32'(v) > hi) return hi;
        return 32'(v);
    endfunction

    // Floor of the square root, saturating at 255.
    function automatic int unsigned floor_root_sat(input int unsigned s);
        int unsigned root;
        if (s >= 65536) return 255;
        root = 0;
        while ((root + 1) * (root + 1) <= s) root++;
        return root;
    endfunction

    // Advance the mirror by one pixel and queue the result it produces, if any.
    function automatic void predict_pixel(input bit [7:0] pix);
        int unsigned  w;
        int unsigned  h;
        int unsigned  r;
        int unsigned  c;
        int           top;
        int           mid;
        int           bot;
        int           gx;
        int           gy;
        int unsigned  sum_sq;
        t_edge_result res;
        w   = eff_dim(cfg_width, LINE_MAX);
        h   = eff_dim(cfg_height, ROWS_MAX);
        r   = pos_row;
        c   = pos_col;
        top = int'(line_older[c]);
        mid = int'(line_newer[c]);
        bot = int'(pix);

        if (r >= 2 && c >= 2 && r < h && c < w) begin
            gx = (win_col[2] + 2 * win_col[5] + bot) - (win_col[0] + 2 * win_col[3] + top);
            gy = (top + 2 * mid + bot) - (win_col[0] + 2 * win_col[1] + win_col[2]);
            sum_sq = unsigned'(gx * gx + gy * gy);
            res.magnitude  = MAG_BITS'(floor_root_sat(sum_sq));
            res.is_edge    = sum_sq > unsigned'(int'(cfg_threshold) * int'(cfg_threshold));
            res.centre_row = POS_BITS'(r - 1);
            res.centre_col = POS_BITS'(c - 1);
            res.frame_last = (r == h - 1) && (c == w - 1);
            edge_results_due.push_back(res);
        end

        win_col[0] = win_col[3];
        win_col[1] = win_col[4];
        win_col[2] = win_col[5];
        win_col[3] = top;
        win_col[4] = mid;
        win_col[5] = bot;
        line_older[c] = 8'(mid);
        line_newer[c] = 8'(bot);

        if (c + 1 >= w) begin
            pos_col = 0;
            pos_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            pos_col = c + 1;
        end
    endfunction

    // Register write; the mirror takes the value at the same edge.
    task automatic write_reg(input logic [IDX_BITS-1:0] idx,
                             input logic [DIM_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            sob_pkg::CFG_IMAGE_WIDTH:    cfg_width = val;
            sob_pkg::CFG_IMAGE_HEIGHT:   cfg_height = val;
            sob_pkg::CFG_EDGE_THRESHOLD: cfg_threshold = val[THR_BITS-1:0];
            default: ;
        endcase
        reg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one pixel beat, in bursts separated by random gaps.
    task automatic send_pixel(input bit [7:0] pix);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(40, 120))
                                                     : int'($urandom_range(1, 24));
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_pixel(pix);
        pixels_sent++;
    endtask

    // Stop offering, wait for every queued result, then let the front end drain.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (edge_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic bit [7:0] next_pixel(input t_pix_mode mode);
        case (mode)
            PIX_NOISE: return 8'($urandom_range(0, 255));
            PIX_SOFT: begin
                if ($urandom_range(0, 31) == 0) pix_base = int'($urandom_range(0, 240));
                return 8'(pix_base + int'($urandom_range(0, 15)));
            end
            default: begin
                if ($urandom_range(0, 5) == 0) pix_base = int'($urandom_range(0, 255));
                return 8'(pix_base);
            end
        endcase
    endfunction

    function automatic logic [DIM_BITS-1:0] random_dim();
        if ($urandom_range(0, 7) == 0) return DIM_BITS'($urandom_range(0, 2));
        return DIM_BITS'($urandom_range(3, 12));
    endfunction

    function automatic logic [DIM_BITS-1:0] random_threshold();
        case ($urandom_range(0, 5))
            0: return 12'd0;
            1: return 12'd255;
            2, 3: return DIM_BITS'($urandom_range(0, 40));
            default: return DIM_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    // Complete the current frame so that the next setting starts on a fresh one.
    task automatic finish_frame(input t_pix_mode mode);
        while (pos_row != 0 || pos_col != 0) send_pixel(next_pixel(mode));
    endtask

    // Threshold left at its reset value; height below the minimum is clamped.
    task automatic test_default_threshold();
        bit [7:0] pattern [9] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                  8'd255, 8'd255, 8'd255};
        write_reg(sob_pkg::CFG_IMAGE_WIDTH, 12'd3);
        write_reg(sob_pkg::CFG_IMAGE_HEIGHT, 12'd1);
        foreach (pattern[k]) send_pixel(pattern[k]);
        settle();
    endtask

    // Clamped width, a write to the unused index, and a magnitude exactly on
    // the threshold next to one above it.
    task automatic test_clamped_size_and_tie();
        bit [7:0] pattern [12] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                   8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2};
        write_reg(sob_pkg::CFG_IMAGE_WIDTH, 12'd2);
        write_reg(sob_pkg::CFG_IMAGE_HEIGHT, 12'd4);
        write_reg(sob_pkg::CFG_EDGE_THRESHOLD, 12'd4);
        write_reg(CFG_SPARE_INDEX, 12'hFFF);
        foreach (pattern[k]) send_pixel(pattern[k]);
        settle();
    endtask

    // The result side holds off long enough for the block to stall its input.
    task automatic test_output_backpressure();
        write_reg(sob_pkg::CFG_IMAGE_WIDTH, 12'd6);
        write_reg(sob_pkg::CFG_IMAGE_HEIGHT, 12'd6);
        write_reg(sob_pkg::CFG_EDGE_THRESHOLD, 12'd32);
        hold_req++;
        repeat (72) send_pixel(next_pixel(PIX_NOISE));
        settle();
    endtask

    // Small random frames, some cut short so geometry changes land mid-frame.
    task automatic test_random_frames();
        int          start;
        int unsigned frame_px;
        int unsigned count;
        t_pix_mode   mode;
        start = pixels_sent;
        mode  = PIX_SOFT;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            settle();
            if (pos_row == 0 && pos_col == 0) begin
                write_reg(sob_pkg::CFG_IMAGE_WIDTH, random_dim());
                write_reg(sob_pkg::CFG_IMAGE_HEIGHT, random_dim());
            end else begin
                // Mid-frame the width only shrinks, so no unwritten column is read.
                if ($urandom_range(0, 1))
                    write_reg(sob_pkg::CFG_IMAGE_WIDTH,
                              DIM_BITS'($urandom_range(0, eff_dim(cfg_width, LINE_MAX))));
                if ($urandom_range(0, 1))
                    write_reg(sob_pkg::CFG_IMAGE_HEIGHT, random_dim());
            end
            write_reg(sob_pkg::CFG_EDGE_THRESHOLD, random_threshold());
            mode     = t_pix_mode'($urandom_range(0, 2));
            frame_px = eff_dim(cfg_width, LINE_MAX) * eff_dim(cfg_height, ROWS_MAX);
            if ($urandom_range(0, 3) == 0) count = $urandom_range(1, frame_px);
            else count = frame_px * $urandom_range(1, 2);
            repeat (count) send_pixel(next_pixel(mode));
        end
        finish_frame(mode);
        settle();
    endtask

    // Width register far beyond the line stores: the clamped row runs on past
    // the small sizes, then a mid-frame cut wraps the column counter.
    task automatic test_widest_row();
        write_reg(sob_pkg::CFG_IMAGE_WIDTH, 12'hFFF);
        write_reg(sob_pkg::CFG_IMAGE_HEIGHT, 12'd3);
        write_reg(sob_pkg::CFG_EDGE_THRESHOLD, random_threshold());
        repeat (WIDE_PIXELS) send_pixel(next_pixel(PIX_STEP));
        settle();
        write_reg(sob_pkg::CFG_IMAGE_WIDTH, 12'd3);
        finish_frame(PIX_STEP);
        settle();
    endtask

    // Height register beyond the row limit: rows run on until a mid-frame cut
    // leaves the row counter above the new bound and it wraps.
    task automatic test_tallest_frame();
        write_reg(sob_pkg::CFG_IMAGE_WIDTH, 12'd3);
        write_reg(sob_pkg::CFG_IMAGE_HEIGHT, 12'd2049);
        write_reg(sob_pkg::CFG_EDGE_THRESHOLD, random_threshold());
        repeat (TALL_PIXELS) send_pixel(next_pixel(PIX_SOFT));
        settle();
        write_reg(sob_pkg::CFG_IMAGE_HEIGHT, 12'd3);
        finish_frame(PIX_SOFT);
        settle();
    endtask

    // Result side: a changing stall pattern, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack      <= hold_req;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= t_rx_mode'($urandom_range(0, 2));
                rx_mode_left <= int'($urandom_range(16, 160));
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_FLOW:   m_axis_tready <= 1'b1;
                RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
                default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Each result beat is matched against the oldest queued expectation.
    always @(posedge i_clk) begin
        t_edge_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (edge_results_due.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual row %0d col %0d",
                         $time, m_axis_tdata[18:8], m_axis_tdata[29:19]);
                error_count++;
            end else begin
                want = edge_results_due.pop_front();
                results_checked++;
                if (m_axis_tuser === 1'b1) edges_seen++;
                if (m_axis_tlast === 1'b1) frame_ends_seen++;
                compare_field("magnitude", 32'(want.magnitude), 32'(m_axis_tdata[7:0]));
                compare_field("centre_row", 32'(want.centre_row), 32'(m_axis_tdata[18:8]));
                compare_field("centre_col", 32'(want.centre_col), 32'(m_axis_tdata[29:19]));
                compare_field("tdata padding", 32'd0, 32'(m_axis_tdata[31:30]));
                compare_field("is_edge", 32'(want.is_edge), 32'(m_axis_tuser));
                compare_field("frame_last", 32'(want.frame_last), 32'(m_axis_tlast));
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_threshold();
        test_clamped_size_and_tie();
        test_output_backpressure();
        test_random_frames();
        test_widest_row();
        test_tallest_frame();

        settle();
        $display("Covered %0d pixels and %0d register writes, with clamped sizes and cuts.",
                 pixels_sent, reg_writes);
        $display("Checked %0d results: %0d edges, %0d frame ends.",
                 results_checked, edges_seen, frame_ends_seen);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches found.", error_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #5000000;
        $display("Watchdog expired with %0d results outstanding.", edge_results_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/sob_pkg.sv
hw/rtl/sob_ram.sv
hw/rtl/sob_fifo.sv
hw/rtl/sob_front.sv
hw/rtl/sob_back.sv
hw/rtl/sobel_edge_threshold.sv
tb/sv/tb_top.sv
